>>> rtl/sesp_pkg.sv
// Package for the sequence event stream parser: widths, phase and kind codes,
// result record, controller/datapath command and status types.
// No dependencies.
package sesp_pkg;

  localparam int ZERO_RUN  = 10;
  localparam int OFF_W     = 32;
  localparam int LA_IDX_W  = $clog2(ZERO_RUN);
  localparam int FILL_W    = $clog2(ZERO_RUN + 1);
  localparam int EVT_W     = 19;
  localparam int DELTA_W   = 28;
  localparam int PADDR_W   = 3;

  localparam logic [EVT_W-1:0] MAX_EVENTS_RST = EVT_W'(262144);

  // register indexes
  localparam logic REG_BASE_OFFSET = 1'b0;
  localparam logic REG_MAX_EVENTS  = 1'b1;

  // parse phases
  localparam logic [3:0] PH_START  = 4'd0;
  localparam logic [3:0] PH_DELTA  = 4'd1;
  localparam logic [3:0] PH_STATUS = 4'd2;
  localparam logic [3:0] PH_D1     = 4'd3;
  localparam logic [3:0] PH_D2     = 4'd4;
  localparam logic [3:0] PH_META   = 4'd5;
  localparam logic [3:0] PH_T1     = 4'd6;
  localparam logic [3:0] PH_T2     = 4'd7;
  localparam logic [3:0] PH_T3     = 4'd8;
  localparam logic [3:0] PH_NONE   = 4'd15;

  // result kinds
  localparam logic [1:0] KIND_EVENT = 2'd0;
  localparam logic [1:0] KIND_FINAL = 2'd1;
  localparam logic [1:0] KIND_IMPL  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [7:0] CC_LOOP     = 8'd99;
  localparam logic [7:0] CC_LOOP_ON  = 8'd20;
  localparam logic [7:0] CC_LOOP_OFF = 8'd30;
  localparam logic [7:0] CC_COUNT_A  = 8'd98;
  localparam logic [7:0] CC_COUNT_B  = 8'd6;
  localparam logic [7:0] LOOP_ENDLESS = 8'd127;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [OFF_W-1:0]   event_offset;
    logic [DELTA_W-1:0] delta_time;
    logic [2:0]         delta_length;
    logic [7:0]         status_byte;
    logic               status_explicit;
    logic [2:0]         data_count;
    logic [7:0]         data_first;
    logic [7:0]         data_second;
    logic               loop_closed;
    logic [OFF_W-1:0]   loop_target;
    logic [7:0]         loop_repeats;
  } result_t;

  typedef struct packed {
    logic [OFF_W-1:0]   off;
    logic [DELTA_W-1:0] delta;
    logic [2:0]         dlen;
    logic [7:0]         status;
    logic               expl;
    logic [2:0]         cnt;
    logic [7:0]         d1;
    logic [7:0]         d2;
  } event_t;

  typedef struct packed {
    logic load;
    logic step;
    logic endfail;
  } dp_cmd_t;

  typedef struct packed {
    logic finished;
    logic err_pend;
    logic fill_full;
    logic fill_nz;
    logic out_free;
  } dp_stat_t;

  // phase that follows a status byte, PH_NONE for an unsupported status
  function automatic logic [3:0] dispatch_phase(input logic [7:0] st);
    logic [3:0] ph;
    ph = PH_NONE;
    case (st[7:4])
      4'h9, 4'hB, 4'hE, 4'hC: ph = PH_D1;
      4'hF:                   ph = (st == ST_META) ? PH_META : PH_NONE;
      default:                ph = PH_NONE;
    endcase
    return ph;
  endfunction

endpackage

>>> rtl/sesp_if.sv
// Stream channel interfaces for the parser: byte input and result output.
// Depends on sesp_pkg.
interface sesp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       first_byte;
  logic       last_byte;
  modport source (output valid, byte_value, first_byte, last_byte, input ready);
  modport sink   (input valid, byte_value, first_byte, last_byte, output ready);
endinterface

interface sesp_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  result_kind;
  logic [sesp_pkg::OFF_W-1:0]  event_offset;
  logic [27:0]                 delta_time;
  logic [2:0]                  delta_length;
  logic [7:0]                  status_byte;
  logic                        status_explicit;
  logic [2:0]                  data_count;
  logic [7:0]                  data_first;
  logic [7:0]                  data_second;
  logic                        loop_closed;
  logic [sesp_pkg::OFF_W-1:0]  loop_target;
  logic [7:0]                  loop_repeats;
  modport source (output valid, result_kind, event_offset, delta_time, delta_length,
                  status_byte, status_explicit, data_count, data_first, data_second,
                  loop_closed, loop_target, loop_repeats, input ready);
  modport sink   (input valid, result_kind, event_offset, delta_time, delta_length,
                  status_byte, status_explicit, data_count, data_first, data_second,
                  loop_closed, loop_target, loop_repeats, output ready);
endinterface

>>> rtl/sesp_regs.sv
// APB-style configuration registers: base offset and event limit.
// Depends on sesp_pkg.
module sesp_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sesp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic [sesp_pkg::OFF_W-1:0]   base_offset,
  output logic [sesp_pkg::EVT_W-1:0]   max_events
);
  import sesp_pkg::*;

  logic [OFF_W-1:0] base_r;
  logic [EVT_W-1:0] max_r;
  logic             wr_en;
  logic             reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      max_r  <= MAX_EVENTS_RST;
    end else if (wr_en) begin
      if (reg_sel == REG_BASE_OFFSET) base_r <= pwdata[OFF_W-1:0];
      else                            max_r  <= pwdata[EVT_W-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (reg_sel == REG_BASE_OFFSET) prdata[OFF_W-1:0] = base_r;
    else                            prdata[EVT_W-1:0] = max_r;
  end

  assign base_offset = base_r;
  assign max_events  = max_r;
endmodule

>>> rtl/sesp_ctrl.sv
// Controller for the parser: accepts a byte, then sequences parse steps,
// the end-of-range drain and the closing error. Depends on sesp_pkg.
module sesp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  input  sesp_pkg::dp_stat_t stat,
  output sesp_pkg::dp_cmd_t  cmd
);
  import sesp_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;
  logic last_r, last_nxt;
  logic need_step;

  assign in_ready  = (state_r == ST_IDLE);
  assign need_step = stat.err_pend || stat.fill_full || (last_r && stat.fill_nz);

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          last_nxt  = in_last;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        // advance one step per cycle while the result slot is free
        if (stat.finished) begin
          state_nxt = ST_IDLE;
        end else if (need_step) begin
          cmd.step = stat.out_free;
        end else if (last_r) begin
          cmd.endfail = stat.out_free;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end
endmodule

>>> rtl/sesp_dp.sv
// Datapath for the parser: lookahead shift line, event decode, loop tracking
// and the result register. Depends on sesp_pkg.
module sesp_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sesp_pkg::dp_cmd_t          cmd,
  output sesp_pkg::dp_stat_t         stat,
  input  logic [7:0]                 in_byte,
  input  logic                       in_first,
  input  logic [sesp_pkg::OFF_W-1:0] base_offset,
  input  logic [sesp_pkg::EVT_W-1:0] max_events,
  output sesp_pkg::result_t          out_data,
  output logic                       out_valid,
  input  logic                       out_ready
);
  import sesp_pkg::*;

  logic [7:0]       la_r   [ZERO_RUN];
  logic [7:0]       la_nxt [ZERO_RUN];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [3:0]       phase_r, phase_nxt;
  logic [OFF_W-1:0] pos_r, pos_nxt;
  logic [7:0]       rs_r, rs_nxt;
  event_t           ev_r, ev_nxt;
  logic             lopen_r, lopen_nxt;
  logic [OFF_W-1:0] lstart_r, lstart_nxt;
  logic [7:0]       lcnt_r, lcnt_nxt;
  logic             ltaken_r, ltaken_nxt;
  logic [EVT_W-1:0] events_r, events_nxt;
  logic             fin_r, fin_nxt;
  logic             errp_r, errp_nxt;
  result_t          out_r, out_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic             all_zero;

  // zero-run detector over the whole lookahead
  always_comb begin
    all_zero = 1'b1;
    for (int i = 0; i < ZERO_RUN; i++) begin
      if (la_r[i] != 8'd0) all_zero = 1'b0;
    end
  end

  assign stat.finished  = fin_r;
  assign stat.err_pend  = errp_r;
  assign stat.fill_full = (fill_r >= FILL_W'(ZERO_RUN));
  assign stat.fill_nz   = (fill_r != '0);
  assign stat.out_free  = !ovalid_r || out_ready;
  assign out_data  = out_r;
  assign out_valid = ovalid_r;

  always_comb begin
    event_t           e;
    logic [3:0]       ph;
    logic [7:0]       b;
    logic [1:0]       pops;
    logic             dbyte;
    logic             do_fail;
    logic             do_done;
    logic             closed;
    logic             fin;
    logic [OFF_W-1:0] pos_new;
    logic [EVT_W-1:0] ev_cnt;
    logic [FILL_W-1:0] fill_e;
    logic             fin_e;

    la_nxt     = la_r;
    fill_nxt   = fill_r;
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    rs_nxt     = rs_r;
    ev_nxt     = ev_r;
    lopen_nxt  = lopen_r;
    lstart_nxt = lstart_r;
    lcnt_nxt   = lcnt_r;
    ltaken_nxt = ltaken_r;
    events_nxt = events_r;
    fin_nxt    = fin_r;
    errp_nxt   = errp_r;
    out_nxt    = out_r;
    ovalid_nxt = out_ready ? 1'b0 : ovalid_r;
    e          = ev_r;
    ph         = phase_r;
    b          = la_r[0];
    pops       = 2'd0;
    dbyte      = 1'b0;
    do_fail    = 1'b0;
    do_done    = 1'b0;
    closed     = 1'b0;
    fin        = 1'b0;
    pos_new    = pos_r;
    ev_cnt     = events_r;
    fill_e     = fill_r;
    fin_e      = fin_r;

    if (cmd.load) begin
      // restart on a first byte, then append unless the sequence has ended
      if (in_first) begin
        fill_e     = '0;
        fin_e      = 1'b0;
        phase_nxt  = PH_START;
        pos_nxt    = base_offset;
        rs_nxt     = '0;
        ev_nxt     = '0;
        lopen_nxt  = 1'b0;
        lstart_nxt = '0;
        lcnt_nxt   = '0;
        ltaken_nxt = 1'b0;
        events_nxt = '0;
        errp_nxt   = 1'b0;
      end
      fin_nxt  = fin_e;
      fill_nxt = fill_e;
      if (!fin_e && fill_e < FILL_W'(ZERO_RUN)) begin
        la_nxt[fill_e[LA_IDX_W-1:0]] = in_byte;
        fill_nxt = fill_e + FILL_W'(1);
      end
    end else if (cmd.endfail) begin
      // range ended before a final event
      out_nxt              = '0;
      out_nxt.result_kind  = KIND_ERROR;
      out_nxt.event_offset = (phase_r == PH_START) ? pos_r : ev_r.off;
      ovalid_nxt = 1'b1;
      fin_nxt    = 1'b1;
      fill_nxt   = '0;
    end else if (cmd.step) begin
      if (errp_r) begin
        // event limit reached
        out_nxt              = '0;
        out_nxt.result_kind  = KIND_ERROR;
        out_nxt.event_offset = pos_r;
        ovalid_nxt = 1'b1;
        fin_nxt    = 1'b1;
        errp_nxt   = 1'b0;
      end else if (fill_r == FILL_W'(ZERO_RUN) && phase_r == PH_START && all_zero) begin
        // implicit end by a zero run
        out_nxt              = '0;
        out_nxt.result_kind  = (events_r == '0) ? KIND_ERROR : KIND_IMPL;
        out_nxt.event_offset = pos_r;
        ovalid_nxt = 1'b1;
        fin_nxt    = 1'b1;
      end else begin
        if (phase_r == PH_START) begin
          e     = '0;
          e.off = pos_r;
          ph    = PH_DELTA;
        end
        pops = 2'd1;
        case (ph)
          PH_DELTA: begin
            e.delta = {e.delta[DELTA_W-8:0], b[6:0]};
            e.dlen  = e.dlen + 3'd1;
            if (!b[7])                ph = PH_STATUS;
            else if (e.dlen >= 3'd4)  do_fail = 1'b1;
          end
          PH_STATUS: begin
            if (b[7]) begin
              e.status = b;
              e.expl   = 1'b1;
              rs_nxt   = b;
              ph       = dispatch_phase(b);
              if (ph == PH_NONE) do_fail = 1'b1;
            end else if (rs_r == 8'd0) begin
              do_fail = 1'b1;
            end else begin
              e.status = rs_r;
              e.expl   = 1'b0;
              ph       = dispatch_phase(rs_r);
              if (ph == PH_NONE) do_fail = 1'b1;
              else               dbyte   = 1'b1;
            end
          end
          default: dbyte = 1'b1;
        endcase

        if (dbyte) begin
          case (ph)
            PH_D1: begin
              e.d1  = b;
              e.cnt = 3'd1;
              if (e.status[7:4] == 4'hC) do_done = 1'b1;
              else                       ph      = PH_D2;
            end
            PH_D2: begin
              e.d2    = b;
              e.cnt   = 3'd2;
              do_done = 1'b1;
            end
            PH_META: begin
              e.d1  = b;
              e.cnt = 3'd1;
              if (b == META_TEMPO) begin
                ph = PH_T1;
              end else if (b == META_EOT) begin
                // swallow one trailing zero
                if (fill_r >= FILL_W'(2) && la_r[1] == 8'd0) begin
                  pops  = 2'd2;
                  e.cnt = 3'd2;
                end
                do_done = 1'b1;
              end else begin
                do_fail = 1'b1;
              end
            end
            PH_T1: begin
              e.d2 = b;
              ph   = PH_T2;
            end
            PH_T2: ph = PH_T3;
            default: begin
              e.cnt   = 3'd4;
              do_done = 1'b1;
            end
          endcase
        end

        // pop consumed bytes
        for (int i = 0; i < ZERO_RUN; i++) begin
          if (pops == 2'd2) begin
            if (i + 2 < ZERO_RUN) la_nxt[i] = la_r[i+2];
          end else begin
            if (i + 1 < ZERO_RUN) la_nxt[i] = la_r[i+1];
          end
        end
        fill_nxt = fill_r - FILL_W'(pops);
        pos_new  = pos_r + OFF_W'(pops);
        pos_nxt  = pos_new;

        if (do_fail) begin
          out_nxt              = '0;
          out_nxt.result_kind  = KIND_ERROR;
          out_nxt.event_offset = e.off;
          ovalid_nxt = 1'b1;
          fin_nxt    = 1'b1;
        end else if (do_done) begin
          out_nxt = '0;
          // loop bracket tracking on controller events
          if (e.status[7:4] == 4'hB) begin
            if (e.d1 == CC_LOOP && e.d2 == CC_LOOP_ON) begin
              lopen_nxt  = 1'b1;
              lstart_nxt = pos_new;
              lcnt_nxt   = '0;
              ltaken_nxt = 1'b0;
            end else if (lopen_r && !ltaken_r && (e.d1 == CC_COUNT_A || e.d1 == CC_COUNT_B)) begin
              lcnt_nxt   = e.d2;
              ltaken_nxt = 1'b1;
            end else if (e.d1 == CC_LOOP && e.d2 == CC_LOOP_OFF && lopen_r) begin
              closed               = 1'b1;
              out_nxt.loop_target  = lstart_r;
              out_nxt.loop_repeats = lcnt_r;
              lopen_nxt            = 1'b0;
            end
          end
          fin = (closed && lcnt_r == LOOP_ENDLESS) || (e.status == ST_META && e.d1 == META_EOT);
          out_nxt.result_kind     = fin ? KIND_FINAL : KIND_EVENT;
          out_nxt.event_offset    = e.off;
          out_nxt.delta_time      = e.delta;
          out_nxt.delta_length    = e.dlen;
          out_nxt.status_byte     = e.status;
          out_nxt.status_explicit = e.expl;
          out_nxt.data_count      = e.cnt;
          out_nxt.data_first      = e.d1;
          out_nxt.data_second     = e.d2;
          out_nxt.loop_closed     = closed;
          ovalid_nxt = 1'b1;
          ev_cnt     = events_r + EVT_W'(1);
          events_nxt = ev_cnt;
          ph         = PH_START;
          if (fin)                        fin_nxt  = 1'b1;
          else if (ev_cnt >= max_events)  errp_nxt = 1'b1;
        end
        ev_nxt    = e;
        phase_nxt = ph;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    la_r       <= la_nxt;
    ev_r       <= ev_nxt;
    out_r      <= out_nxt;
    lstart_r   <= lstart_nxt;
    lcnt_r     <= lcnt_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      phase_r  <= PH_START;
      pos_r    <= '0;
      rs_r     <= '0;
      lopen_r  <= 1'b0;
      ltaken_r <= 1'b0;
      events_r <= '0;
      fin_r    <= 1'b0;
      errp_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      fill_r   <= fill_nxt;
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      rs_r     <= rs_nxt;
      lopen_r  <= lopen_nxt;
      ltaken_r <= ltaken_nxt;
      events_r <= events_nxt;
      fin_r    <= fin_nxt;
      errp_r   <= errp_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end
endmodule

>>> rtl/seq_event_stream_parser_core.sv
// Top level of the sequence event stream parser: channels, configuration port,
// controller and datapath. Depends on sesp_pkg, sesp_if, sesp_regs, sesp_ctrl, sesp_dp.

// The parser takes one sequence byte per transfer and emits one result per
// event, end or error. A byte is taken in a cycle in which the controller is
// idle, then the controller runs one parse step per cycle through a ten-byte
// lookahead shift line and returns to idle. While the lookahead fills a byte
// takes no parse step; once it holds ten bytes each byte adds one step (an
// event limit error adds one more step). A byte that ends the range adds one
// step per held byte (up to ten) plus the closing error when no final event
// came. Steps wait while the single result register is full; a new byte is
// taken while a result waits. Registers: base_offset at 0x0, max_events at
// 0x4.
module seq_event_stream_parser_core (
  input  logic                         clk,
  input  logic                         rst_n,
  sesp_in_if.sink                      in_ch,
  sesp_out_if.source                   out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [sesp_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import sesp_pkg::*;

  logic [OFF_W-1:0] base_offset;
  logic [EVT_W-1:0] max_events;
  dp_cmd_t          cmd;
  dp_stat_t         stat;
  result_t          res;

  assign cfg_pready = 1'b1;

  sesp_regs u_regs (
    .clk, .rst_n,
    .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .base_offset, .max_events
  );

  sesp_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_last(in_ch.last_byte), .in_ready(in_ch.ready),
    .stat, .cmd
  );

  sesp_dp u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_byte(in_ch.byte_value), .in_first(in_ch.first_byte),
    .base_offset, .max_events,
    .out_data(res), .out_valid(out_ch.valid), .out_ready(out_ch.ready)
  );

  assign out_ch.result_kind     = res.result_kind;
  assign out_ch.event_offset    = res.event_offset;
  assign out_ch.delta_time      = res.delta_time;
  assign out_ch.delta_length    = res.delta_length;
  assign out_ch.status_byte     = res.status_byte;
  assign out_ch.status_explicit = res.status_explicit;
  assign out_ch.data_count      = res.data_count;
  assign out_ch.data_first      = res.data_first;
  assign out_ch.data_second     = res.data_second;
  assign out_ch.loop_closed     = res.loop_closed;
  assign out_ch.loop_target     = res.loop_target;
  assign out_ch.loop_repeats    = res.loop_repeats;

`ifndef SYNTHESIS
  // no parse step once the sequence has ended
  a_step_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !stat.finished) else $error("parse step after end");
  // a pending limit error never coexists with an ended sequence
  a_errp: assert property (@(posedge clk) disable iff (!rst_n)
    stat.err_pend |-> !stat.finished) else $error("pending error after end");
  // a step only issues when the result register can take it
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step || cmd.endfail) |-> stat.out_free) else $error("result overwritten");
`endif
endmodule

>>> bench/sesp_test_pkg.sv
// Test-side types for the sequence event stream parser bench: one stimulus
// row of the directed table. Depends on sesp_pkg.
package sesp_test_pkg;
  import sesp_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic       first;
    logic       last;
    logic       typed;   // row carries a typed-in expectation
    result_t    typed_res;
  } stim_row_t;

endpackage

>>> bench/sesp_test_if.sv
// Bench-side note: the channel interfaces come from rtl/sesp_if.sv, reused as is.
// This file holds a small stall-control interface shared by bench processes.
// Depends on nothing.
interface sesp_stall_if;
  logic hold_rx;   // receiver hold-off request for the pressure phase
endinterface

>>> bench/seq_event_stream_parser_core_test.sv
// Testbench for seq_event_stream_parser_core: drives byte transfers and APB
// register writes, predicts every result in-bench and checks field by field.
// Depends on sesp_pkg, sesp_if, sesp_test_pkg, sesp_test_if and the RTL.
module seq_event_stream_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sesp_pkg::*;
  import sesp_test_pkg::*;

  localparam int NR = ZERO_RUN;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  sesp_in_if in_ch ();
  sesp_out_if out_ch ();
  sesp_stall_if stall ();

  seq_event_stream_parser_core uut (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  always #5 clk = ~clk;

  // ---------------- predictor state ----------------
  logic [31:0]      p_base;
  logic [EVT_W-1:0] p_maxev;
  logic [7:0]       la [NR];
  int               la_fill;
  logic [3:0]       phase;
  logic [31:0]      pos;
  logic [7:0]       run_st;
  event_t           ev;
  int               ev_need;
  logic             lp_open;
  logic [31:0]      lp_start;
  logic [7:0]       lp_cnt;
  logic             lp_taken;
  logic [EVT_W-1:0] ev_seen;
  logic             done;

  result_t expected_results[$];
  int n_pred = 0;
  int errors = 0;
  bit idle_rx = 1'b1, idle_tx = 1'b1;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void push_result(input logic [1:0] k, input logic [31:0] off,
                                      input bit with_ev, input logic cl,
                                      input logic [31:0] tgt, input logic [7:0] rep);
    result_t r;
    r = '0;
    r.result_kind = k;
    r.event_offset = off;
    if (with_ev) begin
      r.delta_time = ev.delta;
      r.delta_length = ev.dlen;
      r.status_byte = ev.status;
      r.status_explicit = ev.expl;
      r.data_count = ev.cnt;
      r.data_first = ev.d1;
      r.data_second = ev.d2;
    end
    r.loop_closed = cl;
    r.loop_target = tgt;
    r.loop_repeats = rep;
    expected_results = {expected_results, r};
    n_pred++;
  endfunction

  function automatic void fail_at(input logic [31:0] off);
    push_result(KIND_ERROR, off, 1'b0, 1'b0, '0, '0);
    done = 1'b1;
  endfunction

  function automatic logic [7:0] pop_byte();
    logic [7:0] b;
    b = la[0];
    for (int i = 0; i < NR - 1; i++) la[i] = la[i + 1];
    la_fill--;
    pos = pos + 32'd1;
    return b;
  endfunction

  function automatic void finish_event();
    logic cl, fin;
    logic [31:0] tgt;
    logic [7:0] rep;
    cl = 1'b0; tgt = '0; rep = '0;
    if (ev.status[7:4] == 4'hB) begin
      if (ev.d1 == CC_LOOP && ev.d2 == CC_LOOP_ON) begin
        lp_open = 1'b1; lp_start = pos; lp_cnt = '0; lp_taken = 1'b0;
      end else if (lp_open && !lp_taken && (ev.d1 == CC_COUNT_A || ev.d1 == CC_COUNT_B)) begin
        lp_cnt = ev.d2; lp_taken = 1'b1;
      end else if (ev.d1 == CC_LOOP && ev.d2 == CC_LOOP_OFF && lp_open) begin
        cl = 1'b1; tgt = lp_start; rep = lp_cnt; lp_open = 1'b0;
      end
    end
    fin = (cl && rep == LOOP_ENDLESS) || (ev.status == ST_META && ev.d1 == META_EOT);
    push_result(fin ? KIND_FINAL : KIND_EVENT, ev.off, 1'b1, cl, tgt, rep);
    ev_seen = ev_seen + EVT_W'(1);
    phase = PH_START;
    if (fin) done = 1'b1;
    else if (ev_seen >= p_maxev) fail_at(pos);
  endfunction

  function automatic void take_data(input logic [7:0] b);
    case (phase)
      PH_D1: begin
        ev.d1 = b; ev.cnt = 3'd1;
        if (ev_need == 1) finish_event(); else phase = PH_D2;
      end
      PH_D2: begin ev.d2 = b; ev.cnt = 3'd2; finish_event(); end
      PH_META: begin
        ev.d1 = b; ev.cnt = 3'd1;
        if (b == META_TEMPO) phase = PH_T1;
        else if (b == META_EOT) begin
          if (la_fill > 0 && la[0] == 8'h00) begin
            void'(pop_byte()); ev.cnt = 3'd2;
          end
          finish_event();
        end else fail_at(ev.off);
      end
      PH_T1: begin ev.d2 = b; phase = PH_T2; end
      PH_T2: phase = PH_T3;
      default: begin ev.cnt = 3'd4; finish_event(); end
    endcase
  endfunction

  function automatic bit route_status(input logic [7:0] st);
    if (st[7:4] == 4'h9 || st[7:4] == 4'hB || st[7:4] == 4'hE) begin
      ev_need = 2; phase = PH_D1; return 1'b1;
    end
    if (st[7:4] == 4'hC) begin ev_need = 1; phase = PH_D1; return 1'b1; end
    if (st == ST_META) begin phase = PH_META; return 1'b1; end
    return 1'b0;
  endfunction

  function automatic void parse_one();
    logic [7:0] b;
    bit allz;
    if (phase == PH_START) begin
      if (la_fill == NR) begin
        allz = 1'b1;
        for (int i = 0; i < NR; i++) if (la[i] != 8'h00) allz = 1'b0;
        if (allz) begin
          if (ev_seen == 0) fail_at(pos);
          else begin
            push_result(KIND_IMPL, pos, 1'b0, 1'b0, '0, '0);
            done = 1'b1;
          end
          return;
        end
      end
      ev = '0; ev_need = 0;
      ev.off = pos;
      phase = PH_DELTA;
    end
    b = pop_byte();
    if (phase == PH_DELTA) begin
      ev.delta = {ev.delta[DELTA_W-8:0], b[6:0]};
      ev.dlen = ev.dlen + 3'd1;
      if (!b[7]) phase = PH_STATUS;
      else if (ev.dlen >= 3'd4) fail_at(ev.off);
    end else if (phase == PH_STATUS) begin
      if (b[7]) begin
        ev.status = b; ev.expl = 1'b1; run_st = b;
        if (!route_status(b)) fail_at(ev.off);
      end else begin
        if (run_st == 8'h00) begin fail_at(ev.off); return; end
        ev.status = run_st; ev.expl = 1'b0;
        if (!route_status(run_st)) begin fail_at(ev.off); return; end
        take_data(b);
      end
    end else take_data(b);
  endfunction

  function automatic void restart_parser();
    for (int i = 0; i < NR; i++) la[i] = '0;
    la_fill = 0; phase = PH_START; pos = p_base; run_st = '0; ev = '0;
    lp_open = 1'b0; lp_start = '0; lp_cnt = '0; lp_taken = 1'b0; ev_seen = '0;
    done = 1'b0;
  endfunction

  // advance the predictor by one accepted byte transfer
  function automatic void predict_byte(input logic [7:0] b, input logic f, input logic l);
    if (f) restart_parser();
    if (done) return;
    if (la_fill < NR) begin la[la_fill] = b; la_fill++; end
    while (!done && la_fill >= NR) parse_one();
    if (l) begin
      while (!done && la_fill > 0) parse_one();
      if (!done) fail_at(phase == PH_START ? pos : ev.off);
      la_fill = 0;
      done = 1'b1;
    end
  endfunction

  // ---------------- result checker ----------------
  int rx_gap_cycles = 0;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_t w;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_ch.event_offset, '0);
      end else begin
        w = expected_results.pop_front();
        if (out_ch.result_kind !== w.result_kind)
          report_mismatch("result_kind", out_ch.result_kind, w.result_kind);
        if (out_ch.event_offset !== w.event_offset)
          report_mismatch("event_offset", out_ch.event_offset, w.event_offset);
        if (out_ch.delta_time !== w.delta_time)
          report_mismatch("delta_time", out_ch.delta_time, w.delta_time);
        if (out_ch.delta_length !== w.delta_length)
          report_mismatch("delta_length", out_ch.delta_length, w.delta_length);
        if (out_ch.status_byte !== w.status_byte)
          report_mismatch("status_byte", out_ch.status_byte, w.status_byte);
        if (out_ch.status_explicit !== w.status_explicit)
          report_mismatch("status_explicit", out_ch.status_explicit, w.status_explicit);
        if (out_ch.data_count !== w.data_count)
          report_mismatch("data_count", out_ch.data_count, w.data_count);
        if (out_ch.data_first !== w.data_first)
          report_mismatch("data_first", out_ch.data_first, w.data_first);
        if (out_ch.data_second !== w.data_second)
          report_mismatch("data_second", out_ch.data_second, w.data_second);
        if (out_ch.loop_closed !== w.loop_closed)
          report_mismatch("loop_closed", out_ch.loop_closed, w.loop_closed);
        if (out_ch.loop_target !== w.loop_target)
          report_mismatch("loop_target", out_ch.loop_target, w.loop_target);
        if (out_ch.loop_repeats !== w.loop_repeats)
          report_mismatch("loop_repeats", out_ch.loop_repeats, w.loop_repeats);
      end
    end
  end

  // receiver: random stalls; on request hold off for a counted stretch
  always @(negedge clk) begin
    if (stall.hold_rx === 1'b1 && rx_gap_cycles < 300) begin
      rx_gap_cycles++;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(idle_rx && $urandom_range(99) < 6);
    end
  end

  // ---------------- sender side ----------------
  typedef struct { logic [7:0] b; logic f; logic l; } byte_t;
  byte_t seq_q[$];

  task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
    while (idle_tx && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.byte_value <= b;
    in_ch.first_byte <= f;
    in_ch.last_byte <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_byte(b, f, l);
    @(negedge clk);
  endtask

  // release the channel once nothing more is offered
  task automatic go_quiet();
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic flush_seq();
    foreach (seq_q[i]) send_byte(seq_q[i].b, seq_q[i].f, seq_q[i].l);
    seq_q.delete();
    go_quiet();
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [31:0] v);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (idx == REG_BASE_OFFSET) p_base = v;
    else p_maxev = v[EVT_W-1:0];
  endtask

  function automatic void add(input logic [7:0] b, input logic f = 0, input logic l = 0);
    byte_t x;
    x.b = b; x.f = f; x.l = l;
    seq_q = {seq_q, x};
  endfunction

  // random delta of 1-4 bytes, mostly short
  function automatic void add_delta();
    int n;
    n = ($urandom_range(9) < 7) ? 1 : $urandom_range(4, 2);
    for (int i = 0; i < n - 1; i++) add(8'h80 | 8'($urandom));
    add(8'($urandom_range(127)));
  endfunction

  // well-formed sequence with random content, optionally with one byte mangled
  function automatic void build_sequence(input int nev, input bit mangle = 1'b1);
    logic [7:0] st;
    int k;
    add_delta(); seq_q[0].f = 1'b1;
    add(8'h90 | 8'($urandom_range(15))); add(8'($urandom_range(127)));
    add(8'($urandom_range(127)));
    for (int e = 0; e < nev; e++) begin
      add_delta();
      k = $urandom_range(9);
      case (k)
        0: begin add(8'hC0 | 8'($urandom_range(15))); add(8'($urandom_range(127))); end
        1: begin add(ST_META); add(META_TEMPO); add(8'($urandom)); add(8'($urandom));
                 add(8'($urandom)); end
        2: begin add(8'hB0); add(CC_LOOP); add(CC_LOOP_ON); end
        3: begin add(8'hB0); add($urandom_range(1) ? CC_COUNT_A : CC_COUNT_B);
                 add(8'($urandom_range(127))); end
        4: begin add(8'hB0); add(CC_LOOP); add(CC_LOOP_OFF); end
        5: begin add(8'($urandom_range(127))); add(8'($urandom_range(127))); end
        6: begin st = 8'hE0 | 8'($urandom_range(15)); add(st);
                 add(8'($urandom_range(127))); add(8'($urandom_range(127))); end
        default: begin add(8'h90 | 8'($urandom_range(15)));
                 add(8'($urandom_range(127))); add(8'($urandom_range(127))); end
      endcase
    end
    k = $urandom_range(9);
    if (k < 6) begin
      add_delta(); add(ST_META); add(META_EOT);
      if ($urandom_range(1)) add(8'h00);
    end else if (k < 8) begin
      for (int i = 0; i < NR; i++) add(8'h00);
    end
    if (mangle && $urandom_range(3) == 0)
      seq_q[$urandom_range(seq_q.size() - 1)].b = 8'($urandom);
    seq_q[$].l = 1'b1;
  endfunction

  stim_row_t dir_tab[$];

  function automatic void row(input logic [7:0] b, input logic f, input logic l);
    stim_row_t r;
    r.b = b; r.first = f; r.last = l; r.typed = 1'b0; r.typed_res = '0;
    dir_tab = {dir_tab, r};
  endfunction

  function automatic void row_err(input logic [7:0] b, input logic f, input logic l,
                                  input logic [31:0] off);
    stim_row_t r;
    r.b = b; r.first = f; r.last = l; r.typed = 1'b1; r.typed_res = '0;
    r.typed_res.result_kind = KIND_ERROR; r.typed_res.event_offset = off;
    dir_tab = {dir_tab, r};
  endfunction

  initial begin
    in_ch.valid = 1'b0; in_ch.byte_value = '0; in_ch.first_byte = 1'b0;
    in_ch.last_byte = 1'b0; out_ch.ready = 1'b0;
    stall.hold_rx = 1'b0;
    p_base = '0; p_maxev = MAX_EVENTS_RST;
    restart_parser(); pos = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed table: after-reset errors are typed in, the rest predicted
    row_err(8'h00, 0, 1, 32'd0);          // range end before final, fresh after reset
    row(8'h00, 1, 0); row_err(8'h90, 0, 1, 32'd0);
    row(8'h00, 1, 0); row(8'h40, 0, 0); row(8'h7F, 0, 0);   // running status, no status yet
    row(8'h00, 0, 1);
    row(8'hFF, 1, 0); row(8'hFF, 0, 0); row(8'hFF, 0, 0); row(8'h7F, 0, 0);
    row(8'h80, 0, 0); row(8'hFF, 0, 0); row(8'h01, 0, 0); row(8'hFF, 0, 1); // 4-byte delta, unsupported status
    row(8'h00, 1, 0); row(8'h80, 0, 0); row(8'h00, 0, 0); row(8'h00, 0, 1); // bad status
    row(8'h00, 1, 0); row(8'hFF, 0, 0); row(8'h10, 0, 0); row(8'h00, 0, 1); // bad meta
    foreach (dir_tab[i]) begin
      int before_n;
      before_n = n_pred;
      send_byte(dir_tab[i].b, dir_tab[i].first, dir_tab[i].last);
      if (dir_tab[i].typed) begin
        if (n_pred != before_n + 1)
          report_mismatch("directed row count", i, n_pred - before_n);
        else if (expected_results[$] !== dir_tab[i].typed_res)
          report_mismatch("directed row", i, expected_results[$].event_offset);
      end
    end
    go_quiet();
    // implicit end with no event yet seen, then after events
    for (int i = 0; i < NR; i++) add(8'h00, i == 0, i == NR - 1);
    flush_seq();
    add(8'h00, 1); add(8'h90); add(8'h3C); add(8'h7F);
    for (int i = 0; i < NR; i++) add(8'h00);
    add(8'h00, 0, 1);
    flush_seq();
    drain();

    // registers at extremes, max_events of 1 trips immediately
    apb_write(REG_BASE_OFFSET, 32'hFFFF_FFFC);
    apb_write(REG_MAX_EVENTS, 32'd1);
    build_sequence(2); flush_seq();
    drain();
    apb_write(REG_MAX_EVENTS, 32'd3);
    apb_write(REG_BASE_OFFSET, 32'h8000_0000);
    build_sequence(2); flush_seq();
    drain();
    apb_write(REG_MAX_EVENTS, 32'd262144);
    apb_write(REG_BASE_OFFSET, 32'd0);

    // random sequences: no idling at first, then a long receiver hold-off
    idle_tx = 1'b0; idle_rx = 1'b0;
    for (int s = 0; s < 4; s++) begin
      if (s == 2) begin idle_tx = 1'b1; idle_rx = 1'b1; stall.hold_rx = 1'b1; end
      if (s == 2) build_sequence(3, 1'b0);
      else        build_sequence($urandom_range(2, 1));
      flush_seq();
      if (s == 2) stall.hold_rx = 1'b0;
      if (s == 1) begin
        drain();   // sender waits for every expected result
        apb_write(REG_BASE_OFFSET, $urandom);
        apb_write(REG_MAX_EVENTS, $urandom_range(4, 2));
      end
    end
    drain();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
rtl/sesp_pkg.sv
rtl/sesp_if.sv
rtl/sesp_regs.sv
rtl/sesp_ctrl.sv
rtl/sesp_dp.sv
rtl/seq_event_stream_parser_core.sv
bench/sesp_test_pkg.sv
bench/sesp_test_if.sv
bench/seq_event_stream_parser_core_test.sv
